FILE: rtl/tdpc_pkg.sv
// Package for the trial-division prime counter: word types, queue entry
// and fixed sizes. No dependencies.
`default_nettype none

package tdpc_pkg;

   localparam int NUM_WIDTH   = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int DIGIT_BITS  = 4;   // dividend bits retired per divider cycle
   localparam int QDEPTH      = 2;
   localparam int QADDR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam int DIV_STEPS   = (NUM_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int SHF_W       = DIV_STEPS * DIGIT_BITS;
   localparam int DIV_W       = (NUM_WIDTH + 1) / 2 + 2;  // trial divisor
   localparam int REM_W       = DIV_W + 1;
   localparam int SQ_W        = NUM_WIDTH + 4;            // divisor squared

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] number;
      logic                 range_end;
   } tdpc_req_type;

   typedef struct packed {
      logic                   is_prime;
      logic [COUNT_WIDTH-1:0] prime_count;
      logic [COUNT_WIDTH-1:0] tested_count;
      logic                   last;
   } tdpc_rsp_type;

   // Queue entry: candidate plus front-end classification
   typedef struct packed {
      logic [NUM_WIDTH-1:0] number;
      logic                 last;
      logic                 resolved;  // verdict known without division
      logic                 verdict;
   } tdpc_entry_type;

   typedef struct packed {
      logic           valid;
      tdpc_entry_type entry;
   } tdpc_head_type;

endpackage

`default_nettype wire

FILE: rtl/tdpc_front.sv
// Front end: accepts request words, classifies trivial candidates and
// holds them in a short queue. Depends on tdpc_pkg.
`default_nettype none

module tdpc_front
   import tdpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire tdpc_req_type  req_data,
   output tdpc_head_type      head,
   input  wire logic          pop
);

   tdpc_entry_type            q_mem [QDEPTH];
   logic [QADDR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QADDR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         cnt_ff, cnt_in;
   tdpc_entry_type            cls;
   logic                      push;
   logic                      do_pop;

   // 0 and 1 not prime, 2 and 3 prime, other even numbers composite
   always_comb begin
      cls.number   = req_data.number;
      cls.last     = req_data.range_end;
      cls.resolved = 1'b0;
      cls.verdict  = 1'b0;
      if (req_data.number[NUM_WIDTH-1:1] == '0) begin
         cls.resolved = 1'b1;
      end else if (req_data.number[NUM_WIDTH-1:2] == '0) begin
         cls.resolved = 1'b1;
         cls.verdict  = 1'b1;
      end else if (!req_data.number[0]) begin
         cls.resolved = 1'b1;
      end
   end

   assign req_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (cnt_ff != '0);

   assign head.valid = (cnt_ff != '0);
   assign head.entry = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tdpc_back.sv
// Back end: odd-divisor trial division with a radix-16 remainder unit,
// saturating counters and the response register. Depends on tdpc_pkg.
`default_nettype none

module tdpc_back
   import tdpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tdpc_head_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output tdpc_rsp_type       rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [NUM_WIDTH-1:0]   num_ff, num_in;
   logic                   last_ff, last_in;
   logic                   prime_ff, prime_in;
   logic [DIV_W-1:0]       d_ff, d_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SHF_W-1:0]       shf_ff, shf_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [COUNT_WIDTH-1:0] primes_ff, primes_in;
   logic [COUNT_WIDTH-1:0] tested_ff, tested_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tdpc_rsp_type           rsp_data_ff, rsp_data_in;

   logic [REM_W-1:0]       r_nx;
   logic [SHF_W-1:0]       s_nx;
   logic [REM_W-1:0]       d_ext;
   logic                   out_free;

   assign d_ext    = REM_W'(d_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // DIGIT_BITS restoring steps of n mod d, MSB first
   always_comb begin
      r_nx = rem_ff;
      s_nx = shf_ff;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         r_nx = {r_nx[REM_W-2:0], s_nx[SHF_W-1]};
         s_nx = {s_nx[SHF_W-2:0], 1'b0};
         if (r_nx >= d_ext) begin
            r_nx = r_nx - d_ext;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      last_in      = last_ff;
      prime_in     = prime_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      shf_in       = shf_ff;
      step_in      = step_ff;
      primes_in    = primes_ff;
      tested_in    = tested_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               num_in   = head.entry.number;
               last_in  = head.entry.last;
               prime_in = head.entry.verdict;
               d_in     = DIV_W'(3);
               sq_in    = SQ_W'(9);
               state_in = head.entry.resolved ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sq_ff > SQ_W'(num_ff)) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               shf_in   = SHF_W'(num_ff);
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = r_nx;
            shf_in  = s_nx;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               if (r_nx == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // (d+2)^2 = d^2 + 4(d+1)
                  d_in     = d_ff + DIV_W'(2);
                  sq_in    = sq_ff + (SQ_W'(d_ff + 1'b1) << 2);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               tested_in = (tested_ff == COUNT_MAX) ? tested_ff : tested_ff + 1'b1;
               if (prime_ff && primes_ff != COUNT_MAX) begin
                  primes_in = primes_ff + 1'b1;
               end
               rsp_data_in.is_prime     = prime_ff;
               rsp_data_in.prime_count  = primes_in;
               rsp_data_in.tested_count = tested_in;
               rsp_data_in.last         = last_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      last_ff     <= last_in;
      prime_ff    <= prime_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      shf_ff      <= shf_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primes_ff    <= '0;
         tested_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primes_ff    <= primes_in;
         tested_ff    <= tested_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/trial_division_prime_counter.sv
// Top level of the trial-division prime counter: front end with queue and
// division back end. Depends on tdpc_pkg, tdpc_front and tdpc_back.
//
// Usage: one request word per candidate (number, range_end) on req_*;
// one response word per candidate on rsp_* carrying is_prime, the running
// prime_count and tested_count after this candidate, and last = range_end.
// Both channels are valid/ready; a word moves when both are high.
// 0, 1, even numbers and 2, 3 are settled in the front end and skip the
// remainder unit. Odd candidates from 5 up go through the remainder unit:
// each odd divisor d = 3, 5, ... with d*d <= number takes one check step
// and then a remainder pass of 4 divide steps (4 bits each). The
// remainder unit is the limit; items are worked on one at a time.
// The two-entry queue takes up to two words while the back end is busy, and
// the response register lets the back end finish the next item while a
// response is still waiting. With the receiver stalled, the back end holds
// its finished item, the queue fills and req_ready drops.
// Reset: synchronous, active high; clears both counts, the queue and
// rsp_valid. Range ends do not clear the counts; both saturate at all ones.
`default_nettype none

module trial_division_prime_counter
   import tdpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire tdpc_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output tdpc_rsp_type      rsp_data
);

   tdpc_head_type head;   // oldest queued candidate
   logic          pop;    // back end takes the head

   tdpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   tdpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/tdpc_checker.sv
// Port-level checks for the trial-division prime counter, bound to the top
// level. Depends on tdpc_pkg.
`default_nettype none

module tdpc_checker
   import tdpc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire tdpc_rsp_type rsp_data
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.prime_count <= rsp_data.tested_count)
      else $error("prime count above tested count");

   a_prime_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_prime |-> rsp_data.prime_count != '0)
      else $error("prime reported but not counted");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // queue only fills on an accepted word
   a_full_on_push: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("req_ready dropped with no word offered");

endmodule

bind trial_division_prime_counter tdpc_checker u_tdpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
